[rtl/ipc_pkg.sv]
// Shared constants and types of the interrupt priority controller.
`timescale 1ns / 1ps

package ipc_pkg;

   localparam int NUM_SOURCES = 32;
   localparam int PEND_W      = 32;
   localparam int SRC_ID_W    = 5;
   localparam int PRIO_W      = 3;
   localparam int PRIO_LO_W   = 48;
   localparam int PRIO_HI_W   = 45;
   localparam int PRIO_ALL_W  = PRIO_HI_W + PRIO_LO_W + PRIO_W;
   localparam int CSR_DATA_W  = 48;

   // Each cell of the scan chain covers this many source ids.
   localparam int CELL_SRC    = 8;
   localparam int NUM_CELLS   = (NUM_SOURCES + CELL_SRC - 1) / CELL_SRC;
   localparam int CELL_IDX_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int FLAT_W      = NUM_CELLS * CELL_SRC;

   // Sources that may ever become pending: 1 .. NUM_SOURCES-1.
   localparam logic [PEND_W-1:0] SRC_VALID =
      (NUM_SOURCES >= PEND_W) ? 32'hFFFF_FFFE
                              : (((32'd1 << NUM_SOURCES) - 32'd1) & 32'hFFFF_FFFE);

   localparam logic OP_LINE_EVENT = 1'b0;
   localparam logic OP_COMPLETE   = 1'b1;

   typedef enum logic [1:0] {
      CSR_ENABLE_MASK     = 2'd0,
      CSR_THRESHOLD       = 2'd1,
      CSR_PRIORITIES_LOW  = 2'd2,
      CSR_PRIORITIES_HIGH = 2'd3
   } csr_idx_type;

   // Request as seen by every cell when it updates its pending bits.
   typedef struct packed {
      logic                accept;
      logic                op;
      logic [PEND_W-1:0]   lines;
      logic [SRC_ID_W-1:0] cid;
   } item_type;

   // One request travelling down the scan chain.
   typedef struct packed {
      logic                valid;
      logic                op;
      logic [PEND_W-1:0]   pend;
      logic [PRIO_W-1:0]   best_prio;
      logic [SRC_ID_W-1:0] best_id;
   } stage_type;

endpackage

[rtl/interrupt_priority_controller_core.sv]
// Top level of the interrupt priority controller: config, entry stage, cell chain, output.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | op, irq_lines, complete_id
//   rsp_    | out       | rsp_valid/rsp_stall | claim_id, core_irq, pend_vec
//   csr_    | in        | csr_valid/csr_ready | index, wdata
//
// One request per cycle is taken while req_stall is low; rsp_valid for a request rises after it
// passes the entry register, one scan stage per cell of eight sources, and the output register.
// Reset clears the pending bits, the core interrupt level, all config registers and
// every stage valid. A stalled response holds and the chain backs up stage by stage;
// req_stall rises only when the entry stage is full and cannot move on.
`timescale 1ns / 1ps

module interrupt_priority_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [ipc_pkg::PEND_W-1:0]        req_irq_lines,
   input  logic [ipc_pkg::SRC_ID_W-1:0]      req_complete_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ipc_pkg::SRC_ID_W-1:0]      rsp_claim_id,
   output logic                              rsp_core_irq,
   output logic [ipc_pkg::PEND_W-1:0]        rsp_pend_vec,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  ipc_pkg::csr_idx_type              csr_index,
   input  logic [ipc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ipc_pkg::*;

   logic [PEND_W-1:0]    enable_ff;
   logic [PRIO_W-1:0]    thr_ff;
   logic [PRIO_LO_W-1:0] prio_lo_ff;
   logic [PRIO_HI_W-1:0] prio_hi_ff;
   logic [PRIO_ALL_W-1:0] prio_all;

   item_type             item;
   logic                 accept;
   logic [FLAT_W-1:0]    pend_flat;
   stage_type            s0_ff;
   stage_type            s0_in;
   logic                 s0_ready;
   stage_type            chain [NUM_CELLS+1];
   logic                 rdy [NUM_CELLS+1];

   logic                 out_ready;
   logic                 win_hit;
   logic                 irq_in;
   logic                 irq_ff;
   logic                 rsp_valid_ff;
   logic [SRC_ID_W-1:0]  claim_ff;
   logic                 core_irq_ff;
   logic [PEND_W-1:0]    pend_out_ff;

   // Configuration registers; the user must write them only while the block is idle, which it does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= '0;
         thr_ff     <= '0;
         prio_lo_ff <= '0;
         prio_hi_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE_MASK:     enable_ff  <= csr_wdata[PEND_W-1:0];
            CSR_THRESHOLD:       thr_ff     <= csr_wdata[PRIO_W-1:0];
            CSR_PRIORITIES_LOW:  prio_lo_ff <= csr_wdata[PRIO_LO_W-1:0];
            CSR_PRIORITIES_HIGH: prio_hi_ff <= csr_wdata[PRIO_HI_W-1:0];
            default: ;
         endcase
      end
   end

   // Source 0 has no priority field, so it sits at zero below the others.
   assign prio_all = {prio_hi_ff, prio_lo_ff, {PRIO_W{1'b0}}};

   assign accept      = req_valid && !req_stall;
   assign item.accept = accept;
   assign item.op     = req_op;
   assign item.lines  = req_irq_lines;
   assign item.cid    = req_complete_id;

   // Entry stage captures the pending vector as this request leaves it.
   always_comb begin
      s0_in           = '0;
      s0_in.valid     = accept;
      s0_in.op        = req_op;
      s0_in.pend      = PEND_W'(pend_flat);
      s0_in.best_prio = '0;
      s0_in.best_id   = '0;
   end

   assign s0_ready  = !s0_ff.valid || rdy[0];
   assign req_stall = !s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (s0_ready) begin
         s0_ff <= s0_in;
      end
   end

   assign chain[0] = s0_ff;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      ipc_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cell_idx       (CELL_IDX_W'(k)),
         .item           (item),
         .enable_mask    (enable_ff),
         .thresh         (thr_ff),
         .prio_all       (prio_all),
         .stage_up       (chain[k]),
         .up_ready       (rdy[k]),
         .stage_dn       (chain[k+1]),
         .dn_ready       (rdy[k+1]),
         .pend_next      (pend_flat[k*CELL_SRC +: CELL_SRC])
      );
   end

   // Output register and the core interrupt level, updated in request order.
   assign out_ready       = !rsp_valid_ff || !rsp_stall;
   assign rdy[NUM_CELLS]  = out_ready;
   assign win_hit         = (chain[NUM_CELLS].best_id != '0);
   assign irq_in          = (chain[NUM_CELLS].op == OP_COMPLETE) ? win_hit
                                                                 : (irq_ff | win_hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         irq_ff       <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= chain[NUM_CELLS].valid;
         if (chain[NUM_CELLS].valid) begin
            irq_ff      <= irq_in;
            claim_ff    <= chain[NUM_CELLS].best_id;
            core_irq_ff <= irq_in;
            pend_out_ff <= chain[NUM_CELLS].pend;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_claim_id = claim_ff;
   assign rsp_core_irq = core_irq_ff;
   assign rsp_pend_vec = pend_out_ff;

endmodule

[rtl/ipc_cell.sv]
// One cell of the scan chain: pending bits of eight sources and one scan stage.
`timescale 1ns / 1ps

module ipc_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ipc_pkg::CELL_IDX_W-1:0]    cell_idx,
   input  ipc_pkg::item_type                 item,
   input  logic [ipc_pkg::PEND_W-1:0]        enable_mask,
   input  logic [ipc_pkg::PRIO_W-1:0]        thresh,
   input  logic [ipc_pkg::PRIO_ALL_W-1:0]    prio_all,
   input  ipc_pkg::stage_type                stage_up,
   output logic                              up_ready,
   output ipc_pkg::stage_type                stage_dn,
   input  logic                              dn_ready,
   output logic [ipc_pkg::CELL_SRC-1:0]      pend_next
);
   import ipc_pkg::*;

   logic [CELL_SRC-1:0] pend_ff;
   logic [CELL_SRC-1:0] pend_in;
   stage_type           stage_ff;
   stage_type           stage_in;

   always_comb begin
      logic [SRC_ID_W-1:0] id;
      logic                hit;
      for (int j = 0; j < CELL_SRC; j++) begin
         id  = SRC_ID_W'(CELL_SRC * int'(cell_idx) + j);
         hit = item.lines[id] & enable_mask[id] & SRC_VALID[id];
         pend_in[j] = pend_ff[j];
         if (item.accept) begin
            if (item.op == OP_LINE_EVENT) begin
               pend_in[j] = pend_ff[j] | hit;
            end else begin
               pend_in[j] = pend_ff[j] & (item.cid != id);
            end
         end
      end
   end

   assign pend_next = pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Ascending ids with a strict compare keep the lowest id on a tie.
   always_comb begin
      logic [SRC_ID_W-1:0] id;
      logic [PRIO_W-1:0]   p;
      stage_in = stage_up;
      for (int j = 0; j < CELL_SRC; j++) begin
         id = SRC_ID_W'(CELL_SRC * int'(cell_idx) + j);
         p  = prio_all[PRIO_W * int'(id) +: PRIO_W];
         if (stage_up.pend[id] && (p > thresh) && (p > stage_in.best_prio)) begin
            stage_in.best_prio = p;
            stage_in.best_id   = id;
         end
      end
   end

   assign up_ready = !stage_ff.valid || dn_ready;
   assign stage_dn = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (up_ready) begin
         stage_ff <= stage_in;
      end
   end

endmodule

[rtl/ipc_checker.sv]
// Port-level checks of the interrupt priority controller and their binding.
`timescale 1ns / 1ps

module ipc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [ipc_pkg::SRC_ID_W-1:0]   rsp_claim_id,
   input logic                           rsp_core_irq,
   input logic [ipc_pkg::PEND_W-1:0]     rsp_pend_vec
);
   import ipc_pkg::*;

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_claim_id)
         && $stable(rsp_core_irq) && $stable(rsp_pend_vec))
      else $error("stalled response changed");

   // A winning source always raises the core interrupt.
   a_win_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_claim_id != '0) |-> rsp_core_irq)
      else $error("winner reported without core interrupt");

   // The winner must be pending in the same response.
   a_win_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_claim_id != '0) |-> rsp_pend_vec[rsp_claim_id])
      else $error("winner is not pending");

   // Source 0 never becomes pending.
   a_src0_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_pend_vec[0])
      else $error("source 0 reported pending");

endmodule

bind interrupt_priority_controller_core ipc_checker u_ipc_checker (.*);

[tb/sv/interrupt_priority_controller_core_tb.sv]
// Self-checking testbench for the interrupt priority controller core.
`timescale 1ns / 1ps

module interrupt_priority_controller_core_tb;
   import ipc_pkg::*;

   localparam int PIPE_LATENCY   = NUM_CELLS + 2;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int NUM_PHASES     = 5;

   typedef struct packed {
      logic                op;
      logic [PEND_W-1:0]   lines;
      logic [SRC_ID_W-1:0] cid;
   } irq_request_type;

   typedef struct packed {
      logic [SRC_ID_W-1:0] claim;
      logic                core;
      logic [PEND_W-1:0]   pend;
   } claim_result_type;

   typedef struct packed {
      irq_request_type  rq;
      logic             fixed;
      claim_result_type want;
   } queued_request_type;

   typedef struct {
      logic                  is_csr;
      csr_idx_type           idx;
      logic [CSR_DATA_W-1:0] data;
      queued_request_type    item;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_op = OP_LINE_EVENT;
   logic [PEND_W-1:0]     req_irq_lines = '0;
   logic [SRC_ID_W-1:0]   req_complete_id = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SRC_ID_W-1:0]   rsp_claim_id;
   logic                  rsp_core_irq;
   logic [PEND_W-1:0]     rsp_pend_vec;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_idx_type           csr_index = CSR_ENABLE_MASK;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the controller's registers and state.
   logic [PEND_W-1:0]    enable_cfg = '0;
   logic [PRIO_W-1:0]    thresh_cfg = '0;
   logic [PRIO_LO_W-1:0] prio_lo_cfg = '0;
   logic [PRIO_HI_W-1:0] prio_hi_cfg = '0;
   logic [PEND_W-1:0]    pend_model = '0;
   logic                 irq_model = 1'b0;

   queued_request_type req_queue[$];
   claim_result_type   claims_expected[$];
   directed_row_type   directed_rows[$];
   queued_request_type offer;
   claim_result_type   accepted_claim;
   claim_result_type   arrived_claim;

   int   random_left = 0;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic pressure_go = 1'b0;
   logic hold_rsp = 1'b0;

   int errors = 0;
   int n_requests = 0;
   int n_checked = 0;
   int n_wins = 0;
   int n_settings = 0;
   int n_input_stalls = 0;

   interrupt_priority_controller_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_irq_lines    (req_irq_lines),
      .req_complete_id  (req_complete_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_claim_id     (rsp_claim_id),
      .rsp_core_irq     (rsp_core_irq),
      .rsp_pend_vec     (rsp_pend_vec),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [PRIO_W-1:0] source_prio(int id);
      if (id >= 1 && id <= 16) return prio_lo_cfg[3*(id-1) +: PRIO_W];
      if (id >= 17 && id <= 31) return prio_hi_cfg[3*(id-17) +: PRIO_W];
      return '0;
   endfunction

   // Highest priority above the threshold wins; the scan runs upward, so ties keep
   // the lowest id.
   function automatic logic [SRC_ID_W-1:0] top_source(logic [PEND_W-1:0] pend);
      logic [SRC_ID_W-1:0] best;
      logic [PRIO_W-1:0]   best_p;
      logic [PRIO_W-1:0]   p;
      best   = '0;
      best_p = '0;
      for (int id = 1; id < NUM_SOURCES && id < 32; id++) begin
         p = source_prio(id);
         if (pend[id] && p > thresh_cfg && p > best_p) begin
            best_p = p;
            best   = SRC_ID_W'(id);
         end
      end
      return best;
   endfunction

   function automatic claim_result_type settle_request(irq_request_type rq);
      claim_result_type    res;
      logic [SRC_ID_W-1:0] win;
      if (rq.op == OP_LINE_EVENT) begin
         pend_model = pend_model | (rq.lines & enable_cfg & SRC_VALID);
         win = top_source(pend_model);
         // Without a winner the core interrupt keeps its level.
         if (win != '0) irq_model = 1'b1;
      end else begin
         pend_model = pend_model & ~(32'd1 << rq.cid);
         win = top_source(pend_model);
         irq_model = (win != '0);
      end
      res.claim = win;
      res.core  = irq_model;
      res.pend  = pend_model;
      return res;
   endfunction

   function automatic void store_setting(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ENABLE_MASK:     enable_cfg  = data[PEND_W-1:0];
         CSR_THRESHOLD:       thresh_cfg  = data[PRIO_W-1:0];
         CSR_PRIORITIES_LOW:  prio_lo_cfg = data[PRIO_LO_W-1:0];
         CSR_PRIORITIES_HIGH: prio_hi_cfg = data[PRIO_HI_W-1:0];
         default: ;
      endcase
   endfunction

   // Most completes name the current winner, as an interrupt handler would.
   function automatic irq_request_type next_random_request();
      irq_request_type rq;
      int unsigned     r;
      rq.lines = $urandom;
      rq.cid   = SRC_ID_W'($urandom_range(0, 31));
      r = $urandom_range(0, 99);
      if (r < 45) begin
         rq.op = OP_LINE_EVENT;
         case ($urandom_range(0, 5))
            0: rq.lines = $urandom;
            1: rq.lines = 32'd1 << $urandom_range(0, 31);
            2: rq.lines = '1;
            3: rq.lines = '0;
            default: rq.lines = $urandom & $urandom & $urandom;
         endcase
      end else if (r < 85) begin
         rq.op  = OP_COMPLETE;
         rq.cid = top_source(pend_model);
      end else begin
         rq.op = OP_COMPLETE;
      end
      return rq;
   endfunction

   task automatic add_setting(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      directed_row_type row;
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.data   = data;
      row.item   = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_request(logic op, logic [PEND_W-1:0] lines, logic [SRC_ID_W-1:0] cid);
      directed_row_type row;
      row.is_csr        = 1'b0;
      row.idx           = CSR_ENABLE_MASK;
      row.data          = '0;
      row.item          = '0;
      row.item.rq.op    = op;
      row.item.rq.lines = lines;
      row.item.rq.cid   = cid;
      directed_rows.push_back(row);
   endtask

   task automatic add_check(logic op, logic [PEND_W-1:0] lines, logic [SRC_ID_W-1:0] cid,
                            logic [SRC_ID_W-1:0] claim, logic core, logic [PEND_W-1:0] pend);
      add_request(op, lines, cid);
      directed_rows[$].item.fixed      = 1'b1;
      directed_rows[$].item.want.claim = claim;
      directed_rows[$].item.want.core  = core;
      directed_rows[$].item.want.pend  = pend;
   endtask

   task automatic write_setting(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      store_setting(idx, data);
      n_settings++;
   endtask

   task automatic randomize_settings(bit pressure);
      logic [PEND_W-1:0] en;
      logic [PRIO_W-1:0] th;
      case ($urandom_range(0, 3))
         0: en = '1;
         1: en = $urandom;
         default: en = $urandom | $urandom;
      endcase
      th = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 2)) : PRIO_W'($urandom);
      if (pressure) begin
         en = '1;
         th = '0;
      end
      write_setting(CSR_ENABLE_MASK, CSR_DATA_W'(en));
      // Upper bits of the threshold write carry noise that the block must ignore.
      write_setting(CSR_THRESHOLD, {CSR_DATA_W'($urandom) << PRIO_W} | CSR_DATA_W'(th));
      write_setting(CSR_PRIORITIES_LOW, CSR_DATA_W'({$urandom, $urandom}));
      write_setting(CSR_PRIORITIES_HIGH, CSR_DATA_W'({$urandom, $urandom}));
   endtask

   // Waits until every queued request has gone through and its response arrived.
   task automatic drain();
      do @(posedge clock);
      while (req_queue.size() != 0 || random_left != 0 || req_valid ||
             claims_expected.size() != 0);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic flag_field(string name, logic [PEND_W-1:0] want, logic [PEND_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Request side: the predictor advances on every accepted request.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_claim = settle_request(offer.rq);
            claims_expected.push_back(offer.fixed ? offer.want : accepted_claim);
            n_requests++;
         end
         if (req_valid && req_stall) n_input_stalls++;
         if (!req_valid || !req_stall) begin
            if ((req_queue.size() != 0 || random_left != 0) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               if (req_queue.size() != 0) begin
                  offer = req_queue.pop_front();
               end else begin
                  offer.rq    = next_random_request();
                  offer.fixed = 1'b0;
                  offer.want  = '0;
                  random_left--;
               end
               req_valid       <= 1'b1;
               req_op          <= offer.rq.op;
               req_irq_lines   <= offer.rq.lines;
               req_complete_id <= offer.rq.cid;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (claims_expected.size() == 0) begin
               $display("%0t: response with none expected, actual claim_id %0d", $time,
                        rsp_claim_id);
               errors++;
            end else begin
               arrived_claim = claims_expected.pop_front();
               n_checked++;
               if (arrived_claim.claim != '0) n_wins++;
               flag_field("claim_id", PEND_W'(arrived_claim.claim), PEND_W'(rsp_claim_id));
               flag_field("core_irq", PEND_W'(arrived_claim.core), PEND_W'(rsp_core_irq));
               flag_field("pend_vec", arrived_claim.pend, rsp_pend_vec);
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Long hold-off on the response side so the pipeline fills and backs up.
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAIL interrupt_priority_controller_core");
      $finish;
   end

   initial begin : main_flow
      int phase_count[NUM_PHASES] = '{400, 350, 350, 350, 200};
      int phase_idle[NUM_PHASES]  = '{0, 80, 0, 20, 0};
      int phase_stall[NUM_PHASES] = '{0, 0, 80, 20, 0};

      // Everything disabled after reset.
      add_check(OP_LINE_EVENT, 32'hFFFF_FFFF, 5'd0, 5'd0, 1'b0, 32'h0);
      add_check(OP_COMPLETE, 32'h0, 5'd0, 5'd0, 1'b0, 32'h0);
      // All sources enabled at top priority; the high-priority write has extra bits.
      add_setting(CSR_ENABLE_MASK, 48'h0000_FFFF_FFFF);
      add_setting(CSR_PRIORITIES_LOW, 48'hFFFF_FFFF_FFFF);
      add_setting(CSR_PRIORITIES_HIGH, 48'hFFFF_FFFF_FFFF);
      add_check(OP_LINE_EVENT, 32'hFFFF_FFFF, 5'd0, 5'd1, 1'b1, 32'hFFFF_FFFE);
      add_check(OP_COMPLETE, 32'h0, 5'd1, 5'd2, 1'b1, 32'hFFFF_FFFC);
      add_check(OP_COMPLETE, 32'hFFFF_FFFF, 5'd31, 5'd2, 1'b1, 32'h7FFF_FFFC);
      add_check(OP_COMPLETE, 32'h0, 5'd0, 5'd2, 1'b1, 32'h7FFF_FFFC);
      // Threshold at its top: nothing can win, the line event keeps the level high.
      add_setting(CSR_THRESHOLD, 48'hFFFF_FFFF_FFFF);
      add_check(OP_LINE_EVENT, 32'h0, 5'd0, 5'd0, 1'b1, 32'h7FFF_FFFC);
      add_check(OP_COMPLETE, 32'h0, 5'd0, 5'd0, 1'b0, 32'h7FFF_FFFC);
      add_check(OP_LINE_EVENT, 32'h8000_0000, 5'd0, 5'd0, 1'b0, 32'hFFFF_FFFC);
      // Mixed priorities with ties and zero-priority sources.
      add_setting(CSR_THRESHOLD, 48'd3);
      add_setting(CSR_PRIORITIES_LOW, 48'h5D3C_0B6E_7418);
      add_setting(CSR_PRIORITIES_HIGH, 48'h1C70_E5A9_36F0);
      add_setting(CSR_ENABLE_MASK, 48'h5555_AAAA);
      add_request(OP_COMPLETE, 32'h0, 5'd5);
      add_request(OP_COMPLETE, 32'h0, 5'd16);
      add_request(OP_COMPLETE, 32'h0, 5'd17);
      add_request(OP_LINE_EVENT, 32'h0001_0001, 5'd0);
      add_request(OP_COMPLETE, 32'h0, 5'd30);
      add_request(OP_LINE_EVENT, 32'h0, 5'd31);
      add_setting(CSR_PRIORITIES_LOW, 48'h0);
      add_setting(CSR_PRIORITIES_HIGH, 48'h0);
      add_setting(CSR_THRESHOLD, 48'h0);
      add_request(OP_LINE_EVENT, 32'hFFFF_FFFF, 5'd0);
      add_request(OP_COMPLETE, 32'h0, 5'd2);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            drain();
            write_setting(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            req_queue.push_back(directed_rows[i].item);
         end
      end
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         randomize_settings(ph == NUM_PHASES - 1);
         send_idle_pct = phase_idle[ph];
         stall_pct     = phase_stall[ph];
         if (ph == NUM_PHASES - 1) pressure_go = 1'b1;
         random_left = phase_count[ph];
         drain();
      end

      $display("Checked %0d responses to %0d requests, %0d with a winner, %0d register writes.",
               n_checked, n_requests, n_wins, n_settings);
      $display("Idle and stall mixes changed per phase; requests were held off on %0d cycles.",
               n_input_stalls);
      if (errors == 0) begin
         $display("PASS interrupt_priority_controller_core");
      end else begin
         $display("FAIL interrupt_priority_controller_core");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ipc_pkg.sv
rtl/ipc_cell.sv
rtl/interrupt_priority_controller_core.sv
rtl/ipc_checker.sv
tb/sv/interrupt_priority_controller_core_tb.sv
